/* rtl/core/efs_pkg.sv */
package efs_pkg;

    // Field widths
    localparam int unsigned TIME_W      = 64;
    localparam int unsigned QUAT_W      = 64;
    localparam int unsigned COMP_W      = 16;
    localparam int unsigned PROD_W      = 2 * COMP_W;
    localparam int unsigned DOT_W       = PROD_W + 2;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned THR_W       = 29;
    localparam int unsigned TOTAL_W     = 16;
    localparam int unsigned REASON_W    = 3;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned SRC_W       = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned IN_TDATA_W  = 200;
    localparam int unsigned OUT_TDATA_W = 96;

    // Q1.28 unity
    localparam logic [THR_W-1:0] Q28_ONE = 29'h1000_0000;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Register reset values
    localparam logic [CNT_W-1:0] FAIL_CONFIRM_RST    = 8'd3;
    localparam logic [CNT_W-1:0] RECOVER_CONFIRM_RST = 8'd5;
    localparam logic [CNT_W-1:0] INVALID_CONFIRM_RST = 8'd2;
    localparam logic [THR_W-1:0] THRESHOLD_RST       = 29'd266138951;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAIL_CONFIRM    = 2'd0,
        CFG_RECOVER_CONFIRM = 2'd1,
        CFG_INVALID_CONFIRM = 2'd2,
        CFG_COS_THRESHOLD   = 2'd3
    } t_cfg_idx;

    // Supervisor modes
    typedef enum logic [3:0] {
        MODE_INIT     = 4'b0001,
        MODE_PRIMARY  = 4'b0010,
        MODE_DEGRADED = 4'b0100,
        MODE_INVALID  = 4'b1000
    } t_mode;

    // Mode codes as reported
    localparam logic [MODE_W-1:0] MODE_CODE_INIT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_PRIMARY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_DEGRADED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_INVALID  = 2'd3;

    // Source select codes
    localparam logic [SRC_W-1:0] SRC_NONE    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_PRIMARY = 2'd1;
    localparam logic [SRC_W-1:0] SRC_BACKUP  = 2'd2;

    // Transition reasons
    localparam logic [REASON_W-1:0] REASON_NONE         = 3'd0;
    localparam logic [REASON_W-1:0] REASON_QUALIFIED    = 3'd1;
    localparam logic [REASON_W-1:0] REASON_UNHEALTHY    = 3'd2;
    localparam logic [REASON_W-1:0] REASON_UNOBSERVABLE = 3'd3;
    localparam logic [REASON_W-1:0] REASON_ALL_INVALID  = 3'd4;
    localparam logic [REASON_W-1:0] REASON_RECOVERED    = 3'd5;

    // Timestamp and health flags that travel beside the dot product
    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic              primary_healthy;
        logic              alignment_done;
        logic              nav_observable;
        logic              backup_healthy;
    } t_side;

    // Confirmation thresholds
    typedef struct packed {
        logic [CNT_W-1:0] fail_confirm;
        logic [CNT_W-1:0] recover_confirm;
        logic [CNT_W-1:0] invalid_confirm;
    } t_limits;

    // Stage loads of the continuity pipeline
    typedef struct packed {
        logic prod;
        logic sum;
        logic cmp;
    } t_dot_en;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]   switch_time;
        logic [REASON_W-1:0] switch_reason;
        logic [TOTAL_W-1:0]  switch_count;
        logic                switched;
        logic                navigation_ok;
        logic                velocity_ok;
        logic                position_ok;
        logic                attitude_ok;
        logic [SRC_W-1:0]    source_select;
        logic [MODE_W-1:0]   mode_out;
    } t_result;

    // Saturating confirmation count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

/* rtl/core/efs_dot.sv */
module efs_dot (
    input  logic                          i_clk,
    input  efs_pkg::t_dot_en              i_en,
    input  logic [efs_pkg::QUAT_W-1:0]    i_primary_quat,
    input  logic [efs_pkg::QUAT_W-1:0]    i_backup_quat,
    input  logic [efs_pkg::THR_W-1:0]     i_threshold,
    output logic                          o_close
);

    logic signed [efs_pkg::PROD_W-1:0] r_prod [4];
    logic signed [efs_pkg::DOT_W-1:0]  r_dot;
    logic                              r_close;

    logic [efs_pkg::DOT_W-1:0]   n_neg;
    logic [efs_pkg::DOT_W-2:0]   n_abs;
    logic [efs_pkg::THR_W-1:0]   n_mag;

    // Multiply the four component pairs, one lane each
    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= $signed(i_primary_quat[i*efs_pkg::COMP_W +: efs_pkg::COMP_W])
                           * $signed(i_backup_quat[i*efs_pkg::COMP_W +: efs_pkg::COMP_W]);
            end
        end
    end

    // Sum the products
    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_dot <= efs_pkg::DOT_W'(r_prod[0]) + efs_pkg::DOT_W'(r_prod[1])
                   + efs_pkg::DOT_W'(r_prod[2]) + efs_pkg::DOT_W'(r_prod[3]);
        end
    end

    // Take magnitude, clamp at unity, compare against threshold
    always_comb begin
        n_neg = -r_dot;
        n_abs = r_dot[efs_pkg::DOT_W-1] ? n_neg[efs_pkg::DOT_W-2:0]
                                        : r_dot[efs_pkg::DOT_W-2:0];
        n_mag = (n_abs > (efs_pkg::DOT_W-1)'(efs_pkg::Q28_ONE)) ? efs_pkg::Q28_ONE
                                                               : n_abs[efs_pkg::THR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.cmp) begin
            r_close <= (n_mag >= i_threshold);
        end
    end

    assign o_close = r_close;

endmodule

/* rtl/core/efs_mode.sv */
module efs_mode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  efs_pkg::t_side     i_side,
    input  logic               i_close,
    input  efs_pkg::t_limits   i_limits,
    output efs_pkg::t_result   o_result
);

    efs_pkg::t_mode                   r_mode, n_mode;
    logic [efs_pkg::CNT_W-1:0]        r_fail_cnt, n_fail_cnt;
    logic [efs_pkg::CNT_W-1:0]        r_recover_cnt, n_recover_cnt;
    logic [efs_pkg::CNT_W-1:0]        r_invalid_cnt, n_invalid_cnt;
    logic [efs_pkg::TOTAL_W-1:0]      r_total, n_total;
    logic [efs_pkg::TIME_W-1:0]       r_switch_time, n_switch_time;
    logic [efs_pkg::REASON_W-1:0]     r_reason, n_reason;

    logic                             w_p_ok;
    logic                             w_cont;
    efs_pkg::t_mode                   w_fallback;
    logic                             w_go;
    efs_pkg::t_mode                   w_go_mode;
    logic [efs_pkg::REASON_W-1:0]     w_go_reason;

    // Qualification of this sample
    assign w_p_ok = i_side.primary_healthy & i_side.alignment_done & i_side.nav_observable;
    assign w_cont = w_p_ok & i_side.backup_healthy & i_close;
    assign w_fallback = i_side.backup_healthy ? efs_pkg::MODE_DEGRADED
                                              : efs_pkg::MODE_INVALID;

    // Advance counters and pick a transition
    always_comb begin
        n_fail_cnt    = r_fail_cnt;
        n_recover_cnt = r_recover_cnt;
        n_invalid_cnt = r_invalid_cnt;
        w_go          = 1'b0;
        w_go_mode     = r_mode;
        w_go_reason   = efs_pkg::REASON_NONE;

        unique case (r_mode)
            efs_pkg::MODE_INIT: begin
                n_recover_cnt = w_p_ok ? efs_pkg::sat_inc(r_recover_cnt) : '0;
                if (n_recover_cnt >= i_limits.recover_confirm) begin
                    w_go        = 1'b1;
                    w_go_mode   = efs_pkg::MODE_PRIMARY;
                    w_go_reason = efs_pkg::REASON_QUALIFIED;
                end
            end
            efs_pkg::MODE_PRIMARY: begin
                // hard failure drops at once
                if (!i_side.primary_healthy) begin
                    w_go        = 1'b1;
                    w_go_mode   = w_fallback;
                    w_go_reason = i_side.backup_healthy ? efs_pkg::REASON_UNHEALTHY
                                                        : efs_pkg::REASON_ALL_INVALID;
                end else begin
                    n_fail_cnt = w_p_ok ? '0 : efs_pkg::sat_inc(r_fail_cnt);
                    if (n_fail_cnt >= i_limits.fail_confirm) begin
                        w_go        = 1'b1;
                        w_go_mode   = w_fallback;
                        w_go_reason = i_side.backup_healthy ? efs_pkg::REASON_UNOBSERVABLE
                                                            : efs_pkg::REASON_ALL_INVALID;
                    end
                end
            end
            efs_pkg::MODE_DEGRADED: begin
                n_invalid_cnt = i_side.backup_healthy ? '0 : efs_pkg::sat_inc(r_invalid_cnt);
                n_recover_cnt = w_cont ? efs_pkg::sat_inc(r_recover_cnt) : '0;
                // invalid wins over recovery
                if (n_invalid_cnt >= i_limits.invalid_confirm) begin
                    w_go        = 1'b1;
                    w_go_mode   = efs_pkg::MODE_INVALID;
                    w_go_reason = efs_pkg::REASON_ALL_INVALID;
                end else if (n_recover_cnt >= i_limits.recover_confirm) begin
                    w_go        = 1'b1;
                    w_go_mode   = efs_pkg::MODE_PRIMARY;
                    w_go_reason = efs_pkg::REASON_RECOVERED;
                end
            end
            efs_pkg::MODE_INVALID: begin
                n_recover_cnt = w_cont ? efs_pkg::sat_inc(r_recover_cnt) : '0;
                if (n_recover_cnt >= i_limits.recover_confirm) begin
                    w_go        = 1'b1;
                    w_go_mode   = efs_pkg::MODE_PRIMARY;
                    w_go_reason = efs_pkg::REASON_RECOVERED;
                end
            end
            default: begin
                w_go = 1'b0;
            end
        endcase

        // Clear the confirmation counts on any mode change
        if (w_go) begin
            n_fail_cnt    = '0;
            n_recover_cnt = '0;
            n_invalid_cnt = '0;
        end
    end

    // Apply transition and log it
    always_comb begin
        n_mode        = r_mode;
        n_total       = r_total;
        n_switch_time = r_switch_time;
        n_reason      = r_reason;
        if (w_go) begin
            n_mode        = w_go_mode;
            n_total       = r_total + 1'b1;
            n_switch_time = i_side.sample_time;
            n_reason      = w_go_reason;
        end
    end

    // Hold supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= efs_pkg::MODE_INIT;
            r_fail_cnt    <= '0;
            r_recover_cnt <= '0;
            r_invalid_cnt <= '0;
            r_total       <= '0;
            r_switch_time <= '0;
            r_reason      <= efs_pkg::REASON_NONE;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_fail_cnt    <= n_fail_cnt;
            r_recover_cnt <= n_recover_cnt;
            r_invalid_cnt <= n_invalid_cnt;
            r_total       <= n_total;
            r_switch_time <= n_switch_time;
            r_reason      <= n_reason;
        end
    end

    // Build result from the updated state
    always_comb begin
        o_result               = '0;
        o_result.switched      = w_go;
        o_result.switch_count  = n_total;
        o_result.switch_reason = n_reason;
        o_result.switch_time   = n_switch_time;
        unique case (n_mode)
            efs_pkg::MODE_INIT: begin
                o_result.mode_out      = efs_pkg::MODE_CODE_INIT;
                o_result.source_select = efs_pkg::SRC_NONE;
            end
            efs_pkg::MODE_PRIMARY: begin
                o_result.mode_out      = efs_pkg::MODE_CODE_PRIMARY;
                o_result.source_select = efs_pkg::SRC_PRIMARY;
                o_result.attitude_ok   = 1'b1;
                o_result.position_ok   = 1'b1;
                o_result.velocity_ok   = 1'b1;
                o_result.navigation_ok = 1'b1;
            end
            efs_pkg::MODE_DEGRADED: begin
                o_result.mode_out      = efs_pkg::MODE_CODE_DEGRADED;
                o_result.source_select = efs_pkg::SRC_BACKUP;
                o_result.attitude_ok   = 1'b1;
            end
            efs_pkg::MODE_INVALID: begin
                o_result.mode_out      = efs_pkg::MODE_CODE_INVALID;
                o_result.source_select = efs_pkg::SRC_NONE;
            end
            default: begin
                o_result.mode_out      = efs_pkg::MODE_CODE_INIT;
                o_result.source_select = efs_pkg::SRC_NONE;
            end
        endcase
    end

endmodule

/* rtl/core/estimator_failover_supervisor.sv */
// Channel   Direction  Width  Content
// s_axis    in         200    one estimator sample per request
// m_axis    out        96     supervisor mode, qualification flags, transition log
// cfg       in         29     confirmation counts and handover cos threshold
//
// One sample is accepted every cycle unless a stall on m_axis has backed up to the input;
// each result passes the input register, multiply, sum, compare and result register,
// the input register loading at the accepting edge.
// The mode update runs in the compare-to-result stage, so samples follow back to back.
// i_rst_n is synchronous and active low; it restores the mode, counters, log and
// register defaults. A stall on m_axis backs up stage by stage; bubbles are squeezed out.
module estimator_failover_supervisor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_we,
    input  logic [efs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [efs_pkg::THR_W-1:0]          i_cfg_wdata,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_time[63:0], primary_healthy[64], alignment_done[65], nav_observable[66],
    // backup_healthy[67], primary_quat[131:68], backup_quat[195:132], zero fill
    input  logic [efs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mode_out[1:0], source_select[3:2], attitude_ok[4], position_ok[5],
    // velocity_ok[6], navigation_ok[7], switched[8], switch_count[24:9],
    // switch_reason[27:25], switch_time[91:28], zero fill
    output logic [efs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned RESULT_W = $bits(efs_pkg::t_result);

    // Configuration registers
    efs_pkg::t_limits                r_limits;
    logic [efs_pkg::THR_W-1:0]       r_threshold;

    // Pipeline valid bits
    logic r_v0, r_v1, r_v2, r_v3, r_out_valid;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy_out;
    logic w_step;

    // Pipeline payload
    efs_pkg::t_side                  r_s0_side, r_s1_side, r_s2_side, r_s3_side;
    logic [efs_pkg::QUAT_W-1:0]      r_s0_pq, r_s0_bq;
    efs_pkg::t_side                  w_in_side;
    efs_pkg::t_dot_en                w_dot_en;
    logic                            w_close;
    efs_pkg::t_result                w_result;
    efs_pkg::t_result                r_out;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.fail_confirm    <= efs_pkg::FAIL_CONFIRM_RST;
            r_limits.recover_confirm <= efs_pkg::RECOVER_CONFIRM_RST;
            r_limits.invalid_confirm <= efs_pkg::INVALID_CONFIRM_RST;
            r_threshold              <= efs_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (efs_pkg::t_cfg_idx'(i_cfg_index))
                efs_pkg::CFG_FAIL_CONFIRM:
                    r_limits.fail_confirm <= i_cfg_wdata[efs_pkg::CNT_W-1:0];
                efs_pkg::CFG_RECOVER_CONFIRM:
                    r_limits.recover_confirm <= i_cfg_wdata[efs_pkg::CNT_W-1:0];
                efs_pkg::CFG_INVALID_CONFIRM:
                    r_limits.invalid_confirm <= i_cfg_wdata[efs_pkg::CNT_W-1:0];
                efs_pkg::CFG_COS_THRESHOLD:
                    r_threshold <= i_cfg_wdata;
                default: begin
                    r_threshold <= r_threshold;
                end
            endcase
        end
    end

    // Stage loads: a stage moves when empty or when the next one moves
    assign w_rdy_out     = !r_out_valid || m_axis_tready;
    assign w_rdy3        = !r_v3 || w_rdy_out;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign w_rdy0        = !r_v0 || w_rdy1;
    assign s_axis_tready = w_rdy0;
    assign w_step        = r_v3 && w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy0)    r_v0        <= s_axis_tvalid;
            if (w_rdy1)    r_v1        <= r_v0;
            if (w_rdy2)    r_v2        <= r_v1;
            if (w_rdy3)    r_v3        <= r_v2;
            if (w_rdy_out) r_out_valid <= r_v3;
        end
    end

    // Unpack the request
    assign w_in_side.sample_time     = s_axis_tdata[63:0];
    assign w_in_side.primary_healthy = s_axis_tdata[64];
    assign w_in_side.alignment_done  = s_axis_tdata[65];
    assign w_in_side.nav_observable  = s_axis_tdata[66];
    assign w_in_side.backup_healthy  = s_axis_tdata[67];

    // Input register and sideband delay line
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_s0_side <= w_in_side;
            r_s0_pq   <= s_axis_tdata[131:68];
            r_s0_bq   <= s_axis_tdata[195:132];
        end
        if (w_rdy1) r_s1_side <= r_s0_side;
        if (w_rdy2) r_s2_side <= r_s1_side;
        if (w_rdy3) r_s3_side <= r_s2_side;
    end

    // Attitude continuity
    assign w_dot_en.prod = w_rdy1;
    assign w_dot_en.sum  = w_rdy2;
    assign w_dot_en.cmp  = w_rdy3;

    efs_dot u_dot (
        .i_clk          (i_clk),
        .i_en           (w_dot_en),
        .i_primary_quat (r_s0_pq),
        .i_backup_quat  (r_s0_bq),
        .i_threshold    (r_threshold),
        .o_close        (w_close)
    );

    // Mode supervisor
    efs_mode u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_side   (r_s3_side),
        .i_close  (w_close),
        .i_limits (r_limits),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(efs_pkg::OUT_TDATA_W - RESULT_W)'(0), r_out};

endmodule
